/* rtl/core/ltkm_pkg.sv */
// Shared types, codes and defaults for the loser-tree k-way merge.
package ltkm_pkg;

  localparam int KEY_W = 63;
  localparam int PAY_W = 32;
  localparam int WAY_W = 3;
  localparam int CFG_W = 4;

  localparam int WAYS_DEF         = 8;
  localparam int KEY_BITS_DEF     = 63;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Reset value of ways_in_use before it is capped at the way count.
  localparam int WAYS_IN_USE_RST = 8;

  localparam logic ACT_FILL    = 1'b0;
  localparam logic ACT_REPLACE = 1'b1;

  typedef struct packed {
    logic             action;
    logic [WAY_W-1:0] way;
    logic [KEY_W-1:0] new_key;
    logic [PAY_W-1:0] new_payload;
    logic             stream_ended;
  } item_t;

  typedef struct packed {
    logic [WAY_W-1:0] winner_way;
    logic [KEY_W-1:0] winner_key;
    logic [PAY_W-1:0] winner_payload;
    logic             all_done;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic load;
    logic read;
    logic cmp;
    logic finish;
    logic cfg_write;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic load_ends;
    logic cmp_ends;
  } sts_t;

endpackage

/* rtl/core/ltkm_ctrl.sv */
// Sequencer for the merge: load a head, walk the tree a level at a time, hand over the result.
module ltkm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  output logic          result_valid,
  input  logic          result_stall,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  ltkm_pkg::sts_t sts,
  output ltkm_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    LOAD,
    READ,
    CMP,
    FINISH
  } state_t;

  state_t state;
  logic   can_finish;

  assign can_finish = !result_valid || !result_stall;
  assign item_stall = (state != IDLE);
  assign cfg_ready  = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == IDLE) && item_valid;
    cmd.cfg_write = (state == IDLE) && cfg_valid;
    cmd.load      = (state == LOAD);
    cmd.read      = (state == READ);
    cmd.cmp       = (state == CMP);
    cmd.finish    = (state == FINISH) && can_finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      result_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (item_valid) begin
            state <= LOAD;
          end
        end
        LOAD: begin
          state <= sts.load_ends ? FINISH : READ;
        end
        READ: begin
          state <= CMP;
        end
        CMP: begin
          state <= sts.cmp_ends ? FINISH : READ;
        end
        FINISH: begin
          // hold until the result register is free
          if (can_finish) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/ltkm_dpath.sv */
// Heads, loser nodes, climbing way and result register of the merge.
module ltkm_dpath #(
  parameter int WAYS         = ltkm_pkg::WAYS_DEF,
  parameter int KEY_BITS     = ltkm_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = ltkm_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ltkm_pkg::item_t            item,
  input  logic [ltkm_pkg::CFG_W-1:0] cfg_data,
  input  ltkm_pkg::cmd_t             cmd,
  output ltkm_pkg::sts_t             sts,
  output ltkm_pkg::result_t          result
);

  localparam int IDX_W  = $clog2(WAYS + 1);
  localparam int NODE_W = $clog2(WAYS);
  localparam int HEAD_W = KEY_BITS + PAYLOAD_BITS;
  localparam int N_RST  = (ltkm_pkg::WAYS_IN_USE_RST > WAYS) ? WAYS
                                                             : ltkm_pkg::WAYS_IN_USE_RST;

  // configuration and tree state
  logic [IDX_W-1:0]  n;
  logic [IDX_W-1:0]  loser [1:WAYS-1];
  logic              way_ended [WAYS];
  logic [HEAD_W-1:0] head_mem [WAYS];

  // captured word
  logic                    act;
  logic [ltkm_pkg::WAY_W-1:0] way;
  logic [KEY_BITS-1:0]     in_key;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic                    in_end;

  // climbing way
  logic [IDX_W-1:0]        cw;
  logic [KEY_BITS-1:0]     ck;
  logic [PAYLOAD_BITS-1:0] cp;
  logic                    ce;
  logic [NODE_W-1:0]       t;
  logic                    tgt_ok;

  // opponent read from the tree
  logic [IDX_W-1:0]        other;
  logic [HEAD_W-1:0]       rd_head;
  logic                    oe;

  // current overall winner
  logic [IDX_W-1:0]        win_idx;
  logic [KEY_BITS-1:0]     win_key;
  logic [PAYLOAD_BITS-1:0] win_pay;
  logic                    win_end;

  logic [IDX_W-1:0]        n_new;
  logic [IDX_W-1:0]        target;
  logic                    target_ok;
  logic [IDX_W:0]          leaf;
  logic [NODE_W-1:0]       t_start;
  logic                    after;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [IDX_W-1:0]        fin_idx;
  logic [KEY_BITS-1:0]     fin_key;
  logic [PAYLOAD_BITS-1:0] fin_pay;
  logic                    fin_end;

  assign rd_key = rd_head[HEAD_W-1:PAYLOAD_BITS];
  assign rd_pay = rd_head[PAYLOAD_BITS-1:0];

  // clamp the written way count to 1..WAYS
  always_comb begin
    if (cfg_data == '0) begin
      n_new = IDX_W'(1);
    end else if (32'(cfg_data) > 32'(WAYS)) begin
      n_new = IDX_W'(WAYS);
    end else begin
      n_new = IDX_W'(cfg_data);
    end
  end

  always_comb begin
    target    = n;
    target_ok = 1'b0;
    if (act == ltkm_pkg::ACT_FILL) begin
      if (32'(way) < 32'(n)) begin
        target    = IDX_W'(way);
        target_ok = 1'b1;
      end
    end else begin
      if (win_idx < n && !win_end) begin
        target    = win_idx;
        target_ok = 1'b1;
      end
    end
    leaf    = {1'b0, target} + {1'b0, n};
    t_start = NODE_W'(leaf >> 1);
  end

  // climbing way sorts strictly after the stored loser
  always_comb begin
    if (cw >= n) begin
      after = 1'b0;
    end else if (other >= n) begin
      after = 1'b1;
    end else if (ce) begin
      after = !oe;
    end else if (oe) begin
      after = 1'b0;
    end else begin
      after = ck > rd_key;
    end
  end

  assign sts.load_ends = !target_ok || (t_start == '0);
  assign sts.cmp_ends  = (t >> 1) == '0;

  always_comb begin
    if (tgt_ok) begin
      fin_idx = cw;
      fin_key = ck;
      fin_pay = cp;
      fin_end = ce;
    end else begin
      fin_idx = win_idx;
      fin_key = win_key;
      fin_pay = win_pay;
      fin_end = win_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && target_ok) begin
      head_mem[target[NODE_W-1:0]] <= {in_key, in_pay};
    end
    if (cmd.read) begin
      rd_head <= head_mem[loser[t][NODE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n       <= IDX_W'(N_RST);
      win_idx <= IDX_W'(N_RST);
      for (int i = 1; i < WAYS; i++) begin
        loser[i] <= IDX_W'(N_RST);
      end
      for (int i = 0; i < WAYS; i++) begin
        way_ended[i] <= 1'b0;
      end
    end else if (cmd.cfg_write) begin
      n       <= n_new;
      win_idx <= n_new;
      for (int i = 1; i < WAYS; i++) begin
        loser[i] <= n_new;
      end
      for (int i = 0; i < WAYS; i++) begin
        way_ended[i] <= 1'b0;
      end
    end else begin
      if (cmd.load && target_ok) begin
        way_ended[target[NODE_W-1:0]] <= in_end;
      end
      if (cmd.cmp && after) begin
        loser[t] <= cw;
      end
      if (cmd.finish) begin
        win_idx <= fin_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act    <= item.action;
      way    <= item.way;
      in_key <= item.new_key[KEY_BITS-1:0];
      in_pay <= item.new_payload[PAYLOAD_BITS-1:0];
      in_end <= item.stream_ended;
    end
    if (cmd.load) begin
      tgt_ok <= target_ok;
      cw     <= target;
      ck     <= in_key;
      cp     <= in_pay;
      ce     <= in_end;
      t      <= t_start;
    end
    if (cmd.read) begin
      other <= loser[t];
      oe    <= way_ended[loser[t][NODE_W-1:0]];
    end
    if (cmd.cmp) begin
      // swap: the stored loser climbs on, the old climber stays at this node
      if (after) begin
        cw <= other;
        ck <= rd_key;
        cp <= rd_pay;
        ce <= oe;
      end
      t <= t >> 1;
    end
    if (cmd.finish) begin
      win_key <= fin_key;
      win_pay <= fin_pay;
      win_end <= fin_end;
      if (fin_idx < n) begin
        result.winner_way     <= ltkm_pkg::WAY_W'(fin_idx);
        result.winner_key     <= ltkm_pkg::KEY_W'(fin_key);
        result.winner_payload <= ltkm_pkg::PAY_W'(fin_pay);
        result.all_done       <= fin_end;
      end else begin
        result <= '0;
      end
    end
  end

endmodule

/* rtl/core/loser_tree_kway_merge.sv */
// Top level of the loser-tree k-way merge: controller and datapath.
//
// Input words carry an action (fill a named way, or replace the current
// winner's head), a key, a payload and an end-of-stream flag. A word is
// taken when item_valid is high and item_stall low; every word gives one
// result word on result_valid/result_stall with the winning way, its key,
// its payload and all_done (the winner has ended, so every way has).
// ways_in_use is written on cfg_valid/cfg_ready while no word is in work;
// a write reloads every loser node with the sentinel and clears the ended
// flags, keeping the heads. Values are clamped to 1..WAYS.
// One word is worked at a time: the head is stored, then a read and a
// compare are done for each tree level climbed, then the result is
// loaded; a dropped word skips the tree and goes straight to loading
// the result. A new word is taken only back in idle, once the last one
// has loaded its result, so the single compare unit and the registered
// read of the head memory set the pace.
// After reset ways_in_use is min(8, WAYS) and no way is filled. A stalled
// result holds in its register; the next word is accepted and worked, and
// waits in its last cycle until the result register is free.
module loser_tree_kway_merge #(
  parameter int WAYS         = ltkm_pkg::WAYS_DEF,
  parameter int KEY_BITS     = ltkm_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = ltkm_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  ltkm_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output ltkm_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ltkm_pkg::CFG_W-1:0] cfg_data
);

  ltkm_pkg::cmd_t cmd;
  ltkm_pkg::sts_t sts;

  ltkm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  ltkm_dpath #(
    .WAYS         (WAYS),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .result   (result)
  );

endmodule
